// ===== src/pch_pkg.sv =====
package pch_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // One finished name on its way from the accumulator to the padding stage.
  typedef struct packed {
    logic [31:0] crc;
    logic [1:0]  len;
    logic [7:0]  grp;
    logic        empty;
  } fin_item_t;

  // Status of the padding stage as seen by the accumulator and the top level.
  typedef struct packed {
    logic ready;
    logic busy;
  } pad_stat_t;

  function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                            input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] upcase(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== src/pch_accum.sv =====
module pch_accum (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // char_code [7:0]
  input  logic                  s_tlast,
  input  logic                  s_tuser,   // empty_name [0]
  input  pch_pkg::pad_stat_t    pad_stat,
  output logic                  push,
  output pch_pkg::fin_item_t    push_item
);

  logic        iv;
  logic [7:0]  in_char;
  logic        in_last;
  logic        in_empty;

  logic [31:0] crc_reg;
  logic [1:0]  len_mod4;
  logic [7:0]  group_first_char;

  logic        take;
  logic [7:0]  ch;
  logic [7:0]  grp_eff;
  logic [31:0] crc_fold;
  logic [1:0]  len_inc;

  assign s_tready = !iv || pad_stat.ready;
  assign take     = iv && pad_stat.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (s_tready) begin
      iv <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_char  <= s_tdata;
      in_last  <= s_tlast;
      in_empty <= s_tuser;
    end
  end

  always_comb begin
    ch       = pch_pkg::upcase(in_char);
    grp_eff  = (len_mod4 == 2'd0) ? ch : group_first_char;
    crc_fold = pch_pkg::fold_byte(crc_reg, ch);
    len_inc  = len_mod4 + 2'd1;
  end

  assign push            = take && (in_last || in_empty);
  assign push_item.crc   = crc_fold;
  assign push_item.len   = len_inc;
  assign push_item.grp   = grp_eff;
  assign push_item.empty = in_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_reg          <= pch_pkg::CRC_ONES;
      len_mod4         <= 2'd0;
      group_first_char <= 8'd0;
    end else if (take) begin
      if (in_empty || in_last) begin
        crc_reg          <= pch_pkg::CRC_ONES;
        len_mod4         <= 2'd0;
        group_first_char <= 8'd0;
      end else begin
        crc_reg          <= crc_fold;
        len_mod4         <= len_inc;
        group_first_char <= grp_eff;
      end
    end
  end

endmodule

// ===== src/pch_pad.sv =====
module pch_pad (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  pch_pkg::fin_item_t    push_item,
  output pch_pkg::pad_stat_t    pad_stat,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata    // hash [31:0]
);

  logic                  fv;
  pch_pkg::fin_item_t    fin;
  logic                  out_ready;
  logic                  fin_ready;
  logic [31:0]           crc_pad;
  logic [31:0]           hash_next;

  assign out_ready      = !m_tvalid || m_tready;
  assign fin_ready      = !fv || out_ready;
  assign pad_stat.ready = fin_ready;
  assign pad_stat.busy  = fv;

  // Pad byte first, then copies of the group's first byte up to four bytes.
  always_comb begin
    crc_pad = fin.crc;
    if (fin.len != 2'd0) begin
      crc_pad = pch_pkg::fold_byte(crc_pad, {6'd0, fin.len});
      if (fin.len == 2'd1) begin
        crc_pad = pch_pkg::fold_byte(crc_pad, fin.grp);
      end
      if (fin.len != 2'd3) begin
        crc_pad = pch_pkg::fold_byte(crc_pad, fin.grp);
      end
    end
    hash_next = fin.empty ? 32'd0 : ~crc_pad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (fin_ready) begin
        fv <= push;
      end
      if (out_ready) begin
        m_tvalid <= fv;
      end
    end
    if (push && fin_ready) begin
      fin <= push_item;
    end
    if (fv && out_ready) begin
      m_tdata <= hash_next;
    end
  end

endmodule

// ===== src/padded_crc32_name_hash.sv =====
// Name hash over a byte stream: each slave transaction carries one byte of a
// name, which is upper-cased (only a..z are letters) and folded into a
// reflected CRC-32 (polynomial 0xEDB88320, preset all ones). The transaction
// with tlast set ends the name; if the length is not a multiple of four, one
// pad byte holding the length mod 4 and then copies of the upper-cased byte
// that opened the final four-byte group are folded in before the inverted
// CRC leaves as one master transaction. A transaction with tuser set ends a
// zero-length name, drops any bytes already taken for the current name and
// yields hash 0; its tdata and tlast are ignored. The block takes one byte
// per clock cycle with no gaps between names, unless a stalled master side
// holds it back. A byte sits in the input register, is folded into the
// running CRC as it leaves, the finished name passes a padding stage that
// folds up to three more bytes, and the hash is held in the output
// register. Each of the three registers accepts new data while the
// one after it still holds a transaction, so a stalled master side only
// stops the slave side once all three are full.
module padded_crc32_name_hash (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // char_code [7:0]
  input  logic        s_tlast,   // last byte of the name
  input  logic        s_tuser,   // empty_name [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // hash [31:0]
);

  logic                  push;
  pch_pkg::fin_item_t    push_item;
  pch_pkg::pad_stat_t    pad_stat;

  // Running CRC, length mod 4 and group-start byte live here.
  pch_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .pad_stat  (pad_stat),
    .push      (push),
    .push_item (push_item)
  );

  // Padding, final inversion and the output register.
  pch_pad u_pad (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pad_stat  (pad_stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // The slave side stalls only when every stage is full and the master stalls.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready && pad_stat.busy))
    else $error("slave side stalled while the pipeline had room");

  // A new hash only appears after a finished name sat in the padding stage.
  a_out_from_pad: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(pad_stat.busy))
    else $error("hash presented without a finished name");

  // A finished name only enters the padding stage when it has room.
  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push |-> pad_stat.ready)
    else $error("finished name pushed into a full padding stage");

endmodule
